### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication that checks the consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Delayed implication (|=> ##1): the consequent is checked after the antecedent.
`define ASSERT_NEXT2(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
    else $error(msg);

`endif

### rtl/core/slpc_pkg.sv
// Shared types, codes and constant tables of the status LED pattern controller.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package slpc_pkg;

  localparam int COLOR_W = 24;
  localparam int MS_W    = 16;
  localparam int COUNT_W = 8;
  localparam int PHASE_W = COUNT_W + 1;

  // Input item kinds.
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_SET   = 2'd1,
    MODE_PULSE = 2'd2,
    MODE_FLASH = 2'd3
  } mode_t;

  // LED states; code 7 is unused and is treated as off.
  typedef enum logic [2:0] {
    ST_OFF     = 3'd0,
    ST_NET     = 3'd1,
    ST_MQTT    = 3'd2,
    ST_PULSING = 3'd3,
    ST_ERROR   = 3'd4,
    ST_RESET   = 3'd5,
    ST_RUNNING = 3'd6
  } led_state_t;

  localparam logic [2:0] STATE_CODE_UNUSED = 3'd7;

  localparam logic [MS_W-1:0]    FLASH_LEN_RESET = 16'd250;
  localparam logic [MS_W-1:0]    FLASH_ELAPSED_MAX = '1;
  localparam logic [COLOR_W-1:0] COLOR_BLACK  = 24'h000000;
  localparam logic [COLOR_W-1:0] COLOR_WHITE  = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] COLOR_ORANGE = 24'hFFA500;
  localparam logic [COLOR_W-1:0] COLOR_YELLOW = 24'hFFFF00;
  localparam logic [COLOR_W-1:0] COLOR_RED    = 24'hFF0000;
  localparam logic [COLOR_W-1:0] COLOR_TEAL   = 24'h008080;
  localparam logic [COLOR_W-1:0] COLOR_PURPLE = 24'h800080;

  // One input item.
  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         new_state;
    logic [COUNT_W-1:0] pulse_count;
    logic [COLOR_W-1:0] pulse_color;
    logic [MS_W-1:0]    on_time_ms;
    logic [MS_W-1:0]    off_time_ms;
    logic [2:0]         final_state;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [COLOR_W-1:0] led_color;
    logic [2:0]         led_mode;
    logic               flash_on;
  } result_t;

  // Map a raw state code onto a state; the unused code means off.
  function automatic led_state_t clean_state(input logic [2:0] code);
    led_state_t s;
    if (code == STATE_CODE_UNUSED) begin
      s = ST_OFF;
    end else begin
      s = led_state_t'(code);
    end
    return s;
  endfunction

  // Colour of the on phase of each blink state.
  function automatic logic [COLOR_W-1:0] blink_color(input led_state_t s);
    logic [COLOR_W-1:0] c;
    unique case (s)
      ST_NET:     c = COLOR_ORANGE;
      ST_MQTT:    c = COLOR_YELLOW;
      ST_ERROR:   c = COLOR_RED;
      ST_RESET:   c = COLOR_TEAL;
      ST_RUNNING: c = COLOR_PURPLE;
      default:    c = COLOR_BLACK;
    endcase
    return c;
  endfunction

  // Toggle interval in milliseconds of each blink state.
  function automatic logic [MS_W-1:0] blink_ms(input led_state_t s);
    logic [MS_W-1:0] t;
    unique case (s)
      ST_NET:     t = 16'd300;
      ST_MQTT:    t = 16'd200;
      ST_ERROR:   t = 16'd150;
      ST_RESET:   t = 16'd250;
      ST_RUNNING: t = 16'd1000;
      default:    t = 16'd0;
    endcase
    return t;
  endfunction

endpackage

### rtl/core/slpc_in_stage.sv
// Input register of the status LED pattern controller.
// Depends on slpc_pkg for the item type.
`timescale 1ns / 1ps

module slpc_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  slpc_pkg::item_t item,
  input  logic            take,
  output logic            full,
  output slpc_pkg::item_t item_q
);
  import slpc_pkg::*;

  logic accept;

  // The register can refill in the same cycle that its item moves on.
  assign item_stall = full && !take;
  assign accept     = item_valid && !item_stall;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  // Captured item; holds while waiting for the engine.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

endmodule

### rtl/core/slpc_engine.sv
// State registers and combinational update logic of the LED pattern engine.
// Depends on slpc_pkg for item, result and state types and the colour tables.
`timescale 1ns / 1ps

module slpc_engine #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  slpc_pkg::item_t   item,
  input  logic [15:0]       flash_length_ms,
  output slpc_pkg::result_t result_d
);
  import slpc_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > MS_W) ? TIMER_WIDTH : MS_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
  // A state entry can chain at most three times: requested state, the state
  // restored after a flash, and the final state of a finished sequence.
  localparam int SETTLE_STEPS = 3;

  led_state_t             cur_state,     cur_state_next;
  led_state_t             saved_state,   saved_state_next;
  logic                   flash_active,  flash_active_next;
  logic [MS_W-1:0]        flash_elapsed, flash_elapsed_next;
  logic [TIMER_WIDTH-1:0] phase_elapsed, phase_elapsed_next;
  logic                   phase_on,      phase_on_next;
  logic [PHASE_W-1:0]     phases_done,   phases_done_next;
  logic [PHASE_W-1:0]     phases_total,  phases_total_next;
  logic [COLOR_W-1:0]     seq_color,     seq_color_next;
  logic [MS_W-1:0]        seq_on_ms,     seq_on_ms_next;
  logic [MS_W-1:0]        seq_off_ms,    seq_off_ms_next;
  led_state_t             seq_final,     seq_final_next;
  logic [COLOR_W-1:0]     shown_color,   shown_color_next;

  // A phase is due once its interval has run out or the timer is saturated.
  function automatic logic phase_due(input logic [TIMER_WIDTH-1:0] el,
                                     input logic [MS_W-1:0] iv);
    return (CMP_W'(el) >= CMP_W'(iv)) || (el == TIMER_MAX);
  endfunction

  // Next state: apply the item, then settle any chained state entries.
  always_comb begin
    logic       pend;
    logic       upd;
    led_state_t tgt;

    cur_state_next     = cur_state;
    saved_state_next   = saved_state;
    flash_active_next  = flash_active;
    flash_elapsed_next = flash_elapsed;
    phase_elapsed_next = phase_elapsed;
    phase_on_next      = phase_on;
    phases_done_next   = phases_done;
    phases_total_next  = phases_total;
    seq_color_next     = seq_color;
    seq_on_ms_next     = seq_on_ms;
    seq_off_ms_next    = seq_off_ms;
    seq_final_next     = seq_final;
    shown_color_next   = shown_color;
    pend = 1'b0;
    upd  = 1'b0;
    tgt  = ST_OFF;

    unique case (mode_t'(item.mode))
      MODE_TICK: begin
        if (phase_elapsed != TIMER_MAX) begin
          phase_elapsed_next = phase_elapsed + 1'b1;
        end
        if (flash_active && (flash_elapsed != FLASH_ELAPSED_MAX)) begin
          flash_elapsed_next = flash_elapsed + 1'b1;
        end
        upd = 1'b1;
      end
      MODE_SET: begin
        pend = 1'b1;
        tgt  = clean_state(item.new_state);
      end
      MODE_PULSE: begin
        phases_total_next = {item.pulse_count, 1'b0};
        phases_done_next  = '0;
        seq_color_next    = item.pulse_color;
        seq_on_ms_next    = item.on_time_ms;
        seq_off_ms_next   = item.off_time_ms;
        seq_final_next    = clean_state(item.final_state);
        pend = 1'b1;
        tgt  = ST_PULSING;
      end
      MODE_FLASH: begin
        if (!flash_active) begin
          flash_active_next  = 1'b1;
          flash_elapsed_next = '0;
          saved_state_next   = cur_state;
        end
      end
      default: ;
    endcase

    for (int i = 0; i < SETTLE_STEPS; i++) begin
      // State entry: restart the phase timer so the first phase fires at once.
      if (pend) begin
        pend = 1'b0;
        if (tgt != cur_state_next) begin
          cur_state_next     = tgt;
          phase_elapsed_next = TIMER_MAX;
          phase_on_next      = 1'b0;
          if (tgt != ST_PULSING) begin
            phases_done_next  = '0;
            phases_total_next = '0;
          end
          upd = 1'b1;
        end
      end
      // LED update.
      if (upd) begin
        upd = 1'b0;
        if (flash_active_next) begin
          if (flash_elapsed_next < flash_length_ms) begin
            shown_color_next = COLOR_WHITE;
          end else begin
            flash_active_next = 1'b0;
            pend = 1'b1;
            tgt  = saved_state_next;
          end
        end else begin
          unique case (cur_state_next) inside
            ST_OFF: begin
              shown_color_next = COLOR_BLACK;
            end
            ST_PULSING: begin
              if (phases_done_next >= phases_total_next) begin
                pend = 1'b1;
                tgt  = seq_final_next;
              end else if (phase_due(phase_elapsed_next,
                                     phase_on_next ? seq_on_ms_next : seq_off_ms_next)) begin
                phase_elapsed_next = '0;
                phase_on_next      = !phase_on_next;
                shown_color_next   = phase_on_next ? seq_color_next : COLOR_BLACK;
                phases_done_next   = phases_done_next + 1'b1;
              end
            end
            ST_NET, ST_MQTT, ST_ERROR, ST_RESET, ST_RUNNING: begin
              if (phase_due(phase_elapsed_next, blink_ms(cur_state_next))) begin
                phase_elapsed_next = '0;
                phase_on_next      = !phase_on_next;
                shown_color_next   = phase_on_next ? blink_color(cur_state_next)
                                                   : COLOR_BLACK;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Result of the item being applied.
  always_comb begin
    result_d.led_color = shown_color_next;
    result_d.led_mode  = cur_state_next;
    result_d.flash_on  = flash_active_next;
  end

  // State registers advance once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state     <= ST_OFF;
      saved_state   <= ST_OFF;
      flash_active  <= 1'b0;
      flash_elapsed <= '0;
      phase_elapsed <= TIMER_MAX;
      phase_on      <= 1'b0;
      phases_done   <= '0;
      phases_total  <= '0;
      seq_color     <= COLOR_BLACK;
      seq_on_ms     <= '0;
      seq_off_ms    <= '0;
      seq_final     <= ST_OFF;
      shown_color   <= COLOR_BLACK;
    end else if (step) begin
      cur_state     <= cur_state_next;
      saved_state   <= saved_state_next;
      flash_active  <= flash_active_next;
      flash_elapsed <= flash_elapsed_next;
      phase_elapsed <= phase_elapsed_next;
      phase_on      <= phase_on_next;
      phases_done   <= phases_done_next;
      phases_total  <= phases_total_next;
      seq_color     <= seq_color_next;
      seq_on_ms     <= seq_on_ms_next;
      seq_off_ms    <= seq_off_ms_next;
      seq_final     <= seq_final_next;
      shown_color   <= shown_color_next;
    end
  end

endmodule

### rtl/core/slpc_out_stage.sv
// Result register of the status LED pattern controller.
// Depends on slpc_pkg for the result type.
`timescale 1ns / 1ps

module slpc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  slpc_pkg::result_t result_d,
  output logic              ready,
  output logic              result_valid,
  input  logic              result_stall,
  output slpc_pkg::result_t result
);
  import slpc_pkg::*;

  // The register can take a new result when empty or when its result leaves.
  assign ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_d;
    end
  end

endmodule

### rtl/core/status_led_pattern_controller.sv
// Status LED pattern controller: input register, pattern engine, result register.
// Depends on slpc_pkg, slpc_in_stage, slpc_engine and slpc_out_stage.
//
// Usage:
//   Items arrive on item / item_valid / item_stall: a 1 ms tick, a state change,
//   a pulse sequence start or an action flash. Each transfer yields exactly one
//   result on result / result_valid / result_stall: the LED colour, the LED state
//   and the flash flag after that item.
//   The flash length register is written on cfg_data / cfg_valid / cfg_ready;
//   cfg_ready is always high. Write it only while no item is in flight.
//   Path: input register, then result register, which loads only when it is ready.
//   Throughput: one item per cycle while results are not stalled; the whole
//   state update, including chained state entries, is one pass of logic between
//   the input and result registers. Stalls: a valid result holds in the result
//   register while result_stall is high; the input register still takes one more
//   item, and item_stall rises only when both registers are full.
//   Reset (rst, synchronous): both registers empty, LED off and black, flash
//   idle, flash length 250 ms. No clearing pass is needed.
`timescale 1ns / 1ps

module status_led_pattern_controller #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  slpc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output slpc_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import slpc_pkg::*;

  logic            in_full;
  logic            out_ready;
  logic            step;
  item_t           item_q;
  result_t         result_d;
  logic [MS_W-1:0] flash_length_ms;

  // Configuration register: always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_length_ms <= FLASH_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      flash_length_ms <= cfg_data;
    end
  end

  // An item is applied when it is held and the result register can take it.
  assign step = in_full && out_ready;

  slpc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .take       (step),
    .full       (in_full),
    .item_q     (item_q)
  );

  slpc_engine #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .item            (item_q),
    .flash_length_ms (flash_length_ms),
    .result_d        (result_d)
  );

  slpc_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (step),
    .result_d     (result_d),
    .ready        (out_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### rtl/core/slpc_checker.sv
// Port-level checks of the status LED pattern controller, bound to the top level.
// Depends on slpc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slpc_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input slpc_pkg::result_t result
);
  import slpc_pkg::*;

  // A stalled result stays valid and unchanged.
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

  // An item transfer is followed, after the ASSERT_NEXT2 delay, by a valid result.
  `ASSERT_NEXT2(a_item_gives_result, clk, rst, item_valid && !item_stall, result_valid, "no result after item transfer")

  // The input side stalls only while a result waits on a stalled receiver.
  `ASSERT_IMPL(a_stall_backpressure, clk, rst, item_stall, result_valid && result_stall, "input stalled without output backpressure")

  // Reset empties the result register.
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !result_valid, "result valid right after reset")

endmodule

bind status_led_pattern_controller slpc_checker u_slpc_checker (.*);
